FILE: rtl/sam_pkg.sv
// Shared types and codes for the sorted array map.
package sam_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic signed [31:0] value;
  } sam_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_total;
  } sam_rsp_t;

  typedef struct packed {
    logic       load;
    logic       srch_issue;
    logic       srch_cmp;
    logic       shift_init;
    logic       shift_step;
    logic       write_new;
    logic       dec_count;
    logic       finish;
    logic [1:0] status;
  } sam_ctl_t;

  typedef struct packed {
    logic       srch_open;
    logic       hit;
    logic       full;
    logic       shift_busy;
    logic [1:0] cmd;
  } sam_sts_t;

endpackage

FILE: rtl/sorted_array_map.sv
// Top level of the sorted array map: controller plus datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  request  | start / busy       | req_i  : cmd, key, value
//  result   | done_o (one cycle) | rsp_o  : status, read_value, entry_total
//
// Binary search runs each halving step as a RAM read, then a compare, and ends in a
// decision step and a result step. Insert shifts entries up through the RAM ports
// and then writes the new entry; erase shifts entries down and lowers the count.
// Reset empties the table at once. busy stays high until the result cycle;
// the result register holds no back-pressure, the receiver cannot stall.
module sorted_array_map #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_CHARS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sam_pkg::sam_req_t req_i,
  output logic              done_o,
  output sam_pkg::sam_rsp_t rsp_o
);
  import sam_pkg::*;

  sam_ctl_t ctl;
  sam_sts_t sts;

  sam_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  sam_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_CHARS   (KEY_CHARS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: rtl/sam_ram.sv
// Generic simple dual-port RAM with registered read.
module sam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sam_ctrl.sv
// Control state machine for search, shift and result sequencing.
module sam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sam_pkg::sam_sts_t sts_i,
  output sam_pkg::sam_ctl_t ctl_o
);
  import sam_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SEARCH  = 6'b000010,
    S_COMPARE = 6'b000100,
    S_SHIFT   = 6'b001000,
    S_WRITE   = 6'b010000,
    S_FINISH  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ctl_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          status_d   = ST_OK;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.srch_open) begin
          ctl_o.srch_issue = 1'b1;
          state_d          = S_COMPARE;
        end else begin
          state_d = S_FINISH;
          case (sts_i.cmd)
            CMD_INSERT: begin
              if (sts_i.hit) begin
                status_d = ST_DUP;
              end else if (sts_i.full) begin
                status_d = ST_FULL;
              end else begin
                ctl_o.shift_init = 1'b1;
                state_d          = S_SHIFT;
              end
            end
            CMD_LOOKUP: begin
              status_d = sts_i.hit ? ST_OK : ST_MISSING;
            end
            CMD_ERASE: begin
              if (sts_i.hit) begin
                ctl_o.shift_init = 1'b1;
                state_d          = S_SHIFT;
              end else begin
                status_d = ST_MISSING;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_COMPARE: begin
        ctl_o.srch_cmp = 1'b1;
        state_d        = S_SEARCH;
      end
      S_SHIFT: begin
        if (sts_i.shift_busy) begin
          ctl_o.shift_step = 1'b1;
        end else if (sts_i.cmd == CMD_INSERT) begin
          state_d = S_WRITE;
        end else begin
          ctl_o.dec_count = 1'b1;
          state_d         = S_FINISH;
        end
      end
      S_WRITE: begin
        ctl_o.write_new = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ctl_o.status = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/sam_dp.sv
// Datapath: key and value stores, search bounds, shift pointer and result register.
module sam_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_CHARS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sam_pkg::sam_req_t req_i,
  input  sam_pkg::sam_ctl_t ctl_i,
  output sam_pkg::sam_sts_t sts_o,
  output logic              done_o,
  output sam_pkg::sam_rsp_t rsp_o
);
  import sam_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DROP  = 8 * (8 - KEY_CHARS);
  localparam logic [63:0] KEY_MASK = ~((64'd1 << DROP) - 64'd1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [1:0]         cmd_q;
  logic [63:0]        key_q;
  logic [31:0]        val_q;
  logic [CNT_W-1:0]   lo_q, hi_q, mid_q, cnt_q, ptr_q;
  logic [CNT_W-1:0]   mid, ptr_d;
  logic               hit_q, pend_q;
  logic [IDX_W-1:0]   dst_q, dst_d;
  logic [31:0]        rdval_q;
  logic               done_q;
  sam_rsp_t           rsp_q;

  logic               is_ins, more;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [63:0]        wkey, rkey;
  logic [31:0]        wval, rval;
  logic [31:0]        cnt_ext;

  assign is_ins = (cmd_q == CMD_INSERT);
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign more   = is_ins ? (ptr_q > lo_q) : (ptr_q < cnt_q);

  always_comb begin
    raddr = mid[IDX_W-1:0];
    ptr_d = ptr_q;
    dst_d = dst_q;
    if (ctl_i.shift_step && more) begin
      if (is_ins) begin
        ptr_d = ptr_q - 1'b1;
        raddr = ptr_d[IDX_W-1:0];
        dst_d = ptr_q[IDX_W-1:0];
      end else begin
        ptr_d = ptr_q + 1'b1;
        raddr = ptr_q[IDX_W-1:0];
        dst_d = IDX_W'(ptr_q - 1'b1);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = dst_q;
    wkey  = rkey;
    wval  = rval;
    if (ctl_i.write_new) begin
      we    = 1'b1;
      waddr = lo_q[IDX_W-1:0];
      wkey  = key_q;
      wval  = val_q;
    end else if (ctl_i.shift_step && pend_q) begin
      we = 1'b1;
    end
  end

  sam_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wkey),
    .raddr_i (raddr),
    .rdata_o (rkey)
  );

  sam_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wval),
    .raddr_i (raddr),
    .rdata_o (rval)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.finish;
      if (ctl_i.shift_init) begin
        pend_q <= 1'b0;
      end else if (ctl_i.shift_step) begin
        pend_q <= more;
      end
      if (ctl_i.write_new) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctl_i.dec_count) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= req_i.cmd;
      key_q   <= req_i.key & KEY_MASK;
      val_q   <= req_i.value;
      lo_q    <= '0;
      hi_q    <= cnt_q;
      hit_q   <= 1'b0;
      rdval_q <= '0;
    end
    if (ctl_i.srch_issue) begin
      mid_q <= mid;
    end
    if (ctl_i.srch_cmp) begin
      if (rkey < key_q) begin
        lo_q <= mid_q + 1'b1;
      end else begin
        hi_q <= mid_q;
      end
      if (rkey == key_q) begin
        hit_q   <= 1'b1;
        rdval_q <= rval;
      end
    end
    if (ctl_i.shift_init) begin
      ptr_q <= is_ins ? cnt_q : CNT_W'(lo_q + 1'b1);
    end else begin
      ptr_q <= ptr_d;
    end
    dst_q <= dst_d;
    if (ctl_i.finish) begin
      rsp_q.status      <= ctl_i.status;
      rsp_q.read_value  <= (cmd_q == CMD_LOOKUP && hit_q) ? rdval_q : '0;
      rsp_q.entry_total <= cnt_ext[6:0];
    end
  end

  assign cnt_ext = 32'(cnt_q);

  assign sts_o.srch_open  = (lo_q < hi_q);
  assign sts_o.hit        = hit_q;
  assign sts_o.full       = (cnt_q == DEPTH_C);
  assign sts_o.shift_busy = more || pend_q;
  assign sts_o.cmd        = cmd_q;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: tb/sv/sam_map_checker.sv
// Checker for the sorted array map: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module sam_map_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_CHARS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  sam_pkg::sam_req_t req_i,
  input  logic              done_i,
  input  sam_pkg::sam_rsp_t rsp_i,
  output int                fail_count_o,
  output int                pending_o
);
  import sam_pkg::*;

  localparam logic [63:0] KEY_MASK = (KEY_CHARS >= 8) ? {64{1'b1}} :
                                     ~((64'd1 << (8 * (8 - KEY_CHARS))) - 64'd1);
  localparam int EXP_DEPTH = 8;

  logic [63:0]        map_keys[TABLE_DEPTH];
  logic signed [31:0] map_vals[TABLE_DEPTH];
  int unsigned        map_count = 0;
  sam_rsp_t           exp_ring[EXP_DEPTH];
  int                 exp_head = 0;
  int                 exp_tail = 0;
  int                 mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic sam_rsp_t map_apply(input sam_req_t r);
    sam_rsp_t    res;
    logic [63:0] k;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    bit          hit;
    res = '0;
    k   = r.key & KEY_MASK;
    lo  = 0;
    hi  = map_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (map_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < map_count) && (map_keys[lo] == k);
    case (r.cmd)
      CMD_INSERT: begin
        if (hit) begin
          res.status = ST_DUP;
        end else if (map_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = map_count; i > lo; i--) begin
            map_keys[i] = map_keys[i - 1];
            map_vals[i] = map_vals[i - 1];
          end
          map_keys[lo] = k;
          map_vals[lo] = r.value;
          map_count++;
        end
      end
      CMD_LOOKUP: begin
        if (hit) res.read_value = map_vals[lo];
        else res.status = ST_MISSING;
      end
      CMD_ERASE: begin
        if (hit) begin
          for (i = lo; i + 1 < map_count; i++) begin
            map_keys[i] = map_keys[i + 1];
            map_vals[i] = map_vals[i + 1];
          end
          map_count--;
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: ;
    endcase
    res.entry_total = 7'(map_count);
    return res;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sam_rsp_t want;
    if (!rst_ni) begin
      map_count = 0;
      exp_head  = 0;
      exp_tail  = 0;
    end else begin
      if (done_i) begin
        if (exp_tail == exp_head) begin
          $display("%0t: result with none expected, actual status %0d value %0d total %0d",
                   $time, rsp_i.status, rsp_i.read_value, rsp_i.entry_total);
          mismatches++;
        end else begin
          want = exp_ring[exp_head % EXP_DEPTH];
          exp_head++;
          if (rsp_i.status !== want.status)
            report_field("status", want.status, rsp_i.status);
          if (rsp_i.read_value !== want.read_value)
            report_field("read_value", want.read_value, rsp_i.read_value);
          if (rsp_i.entry_total !== want.entry_total)
            report_field("entry_total", want.entry_total, rsp_i.entry_total);
        end
      end
      if (start_i && !busy_i) begin
        exp_ring[exp_tail % EXP_DEPTH] = map_apply(req_i);
        exp_tail++;
      end
    end
    pending_o    <= exp_tail - exp_head;
    fail_count_o <= mismatches;
  end

endmodule

FILE: tb/sv/tb_sorted_array_map.sv
// Testbench top for the sorted array map: drives requests, runs the checker, gives the verdict.
`timescale 1ns / 1ps
module tb_sorted_array_map;
  import sam_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int KEY_CHARS    = 8;
  localparam int POOL_SIZE    = 128;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic     clk_i    = 1'b0;
  logic     rst_ni   = 1'b0;
  logic     start    = 1'b0;
  sam_req_t req_item = '0;
  logic     busy;
  logic     done_o;
  sam_rsp_t rsp_item;
  int       fail_count;
  int       pending;
  int       quiet_cycles = 0;
  bit       idle_on = 1'b1;
  logic [63:0] key_pool[POOL_SIZE];

  always #10 clk_i = ~clk_i;

  sorted_array_map #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS  (KEY_CHARS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_item),
    .done_o(done_o),
    .rsp_o (rsp_item)
  );

  sam_map_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS  (KEY_CHARS)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_item),
    .done_i      (done_o),
    .rsp_i       (rsp_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** sorted_array_map: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] text_key(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < s.len()) k[63 - 8 * i -: 8] = s[i];
    end
    return k;
  endfunction

  function automatic sam_req_t make_req(input logic [1:0] cmd, input logic [63:0] key,
                                        input logic [31:0] value);
    sam_req_t r;
    r.cmd   = cmd;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  task automatic send_item(input sam_req_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    req_item <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    int          len;
    int          roll;
    int          w_ins;
    int          w_look;
    int          w_erase;
    logic [1:0]  cmd;
    logic [63:0] key;

    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: key_pool[i] = {$urandom, $urandom};
        1: begin
          key_pool[i] = '0;
          len = $urandom_range(1, 8);
          for (int j = 0; j < len; j++) key_pool[i][63 - 8 * j -: 8] = 8'($urandom_range(97, 122));
        end
        2: key_pool[i] = 64'(i);
        default: key_pool[i] = {1'b1, 31'($urandom), 32'($urandom)};
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_req(CMD_LOOKUP, text_key("apple"), 32'd0));
    send_item(make_req(CMD_ERASE,  64'd0, 32'd0));
    send_item(make_req(CMD_INSERT, 64'd0, 32'h8000_0000));
    send_item(make_req(CMD_INSERT, {64{1'b1}}, 32'h7fff_ffff));
    send_item(make_req(CMD_INSERT, 64'h8000_0000_0000_0000, 32'hffff_ffff));
    send_item(make_req(CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'd0));
    send_item(make_req(CMD_INSERT, text_key("apple"), 32'd1));
    send_item(make_req(CMD_INSERT, text_key("app"), 32'd2));
    send_item(make_req(CMD_INSERT, 64'd0, 32'd5));
    send_item(make_req(CMD_LOOKUP, 64'd0, 32'd0));
    send_item(make_req(CMD_LOOKUP, {64{1'b1}}, 32'd0));
    send_item(make_req(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'd0));
    send_item(make_req(CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, 32'd0));
    send_item(make_req(CMD_LOOKUP, text_key("app"), 32'd0));
    send_item(make_req(CMD_LOOKUP, text_key("apples"), 32'd0));
    send_item(make_req(CMD_ERASE,  text_key("apple"), 32'd0));
    send_item(make_req(CMD_LOOKUP, text_key("apple"), 32'd0));
    send_item(make_req(CMD_ERASE,  text_key("apple"), 32'd0));
    send_item(make_req(CMD_SPARE,  {64{1'b1}}, 32'hffff_ffff));
    send_item(make_req(CMD_SPARE,  64'd0, 32'd0));
    send_item(make_req(CMD_ERASE,  64'd0, 32'd0));
    send_item(make_req(CMD_ERASE,  {64{1'b1}}, 32'd0));
    send_item(make_req(CMD_INSERT, text_key("apple"), 32'h5555_5555));
    send_item(make_req(CMD_LOOKUP, text_key("apple"), 32'd0));
    send_item(make_req(CMD_INSERT, text_key("zzzzzzzz"), 32'haaaa_aaaa));

    for (int p = 0; p < PHASES; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (p % 3)
        0: begin w_ins = 88; w_look = 6;  w_erase = 4;  end
        1: begin w_ins = 35; w_look = 35; w_erase = 28; end
        default: begin w_ins = 10; w_look = 25; w_erase = 63; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_ins) cmd = CMD_INSERT;
        else if (roll < w_ins + w_look) cmd = CMD_LOOKUP;
        else if (roll < w_ins + w_look + w_erase) cmd = CMD_ERASE;
        else cmd = CMD_SPARE;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = {$urandom, $urandom};
        send_item(make_req(cmd, key, $urandom));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** sorted_array_map: PASSED **");
    end else begin
      $display("** sorted_array_map: FAILED **");
    end
    $finish;
  end

endmodule
